// ===== hdl/multi_offset_xor_pad_decrypt_top_defines.svh =====
// Assertion macros shared by the pad decrypt RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTI_OFFSET_XOR_PAD_DECRYPT_TOP_DEFINES_SVH
`define MULTI_OFFSET_XOR_PAD_DECRYPT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MXPD_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define MXPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MXPD_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define MXPD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mxpd_pkg.sv =====
// Types and fixed constants of the multi-offset pad decryptor.
// No dependencies; imported by every module of the block.
package mxpd_pkg;

   localparam int DIVIDEND_W    = 32;
   localparam int PAD_LENGTH_W  = 18;
   localparam int TOKEN_W       = 32;
   localparam int BYTE_W        = 8;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int WORD_BYTES    = 4;

   localparam logic [PAD_LENGTH_W-1:0] PAD_LENGTH_RESET = 18'h20000;
   localparam logic [TOKEN_W-1:0]      TOKEN_RESET      = 32'd1337;

   localparam logic REG_PAD_LENGTH = 1'b0;
   localparam logic REG_PAD_SHIFT  = 1'b1;

   localparam logic CMD_PAD  = 1'b0;
   localparam logic CMD_FILE = 1'b1;

   typedef enum logic [1:0] {
      SEL_ASM,
      SEL_TOKEN,
      SEL_OFFSET,
      SEL_POS
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR_START,
      ST_HDR_WAIT,
      ST_TOK_START,
      ST_TOK_WAIT,
      ST_RED_START,
      ST_RED_WAIT,
      ST_POS_START,
      ST_POS_WAIT,
      ST_BASE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        ready;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_store;
      logic        idx_clear;
      logic        idx_step;
      logic        stale_clear;
      logic        base_load;
      logic        issue;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic accept_hdr_word;
      logic accept_data;
      logic stale;
      logic div_busy;
      logic div_done;
      logic idx_last;
      logic pipe_empty;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/mxpd_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo the pad length, one bit a cycle.
// Depends on mxpd_pkg and the assertion macro header.
`include "multi_offset_xor_pad_decrypt_top_defines.svh"
module mxpd_rem #(
   parameter int LW = 18
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mxpd_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [LW-1:0]                   divisor,
   output logic                            busy,
   output logic                            done,
   output logic [LW-1:0]                   rem
);
   import mxpd_pkg::*;

   localparam int CNTW = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [LW-1:0]         rem_ff, rem_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [LW:0]           trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNTW'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = LW'(trial - {1'b0, divisor});
         end else begin
            rem_in = LW'(trial);
         end
         quo_in = quo_ff << 1;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

   `MXPD_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, done_ff, rem_ff < divisor)

endmodule

// ===== hdl/mxpd_ctrl.sv =====
// Controller state machine: sequences header reduction, re-reduction and pad reads.
// Depends on mxpd_pkg and the assertion macro header.
`include "multi_offset_xor_pad_decrypt_top_defines.svh"
module mxpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  mxpd_pkg::status_type status,
   output mxpd_pkg::cmd_type    cmd
);
   import mxpd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = SEL_ASM;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.accept_hdr_word) begin
               state_in = ST_HDR_START;
            end else if (status.accept_data) begin
               state_in = status.stale ? ST_TOK_START : ST_BASE;
            end
         end
         ST_HDR_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_HDR_WAIT;
         end
         ST_HDR_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TOK_START: begin
            cmd.div_sel   = SEL_TOKEN;
            cmd.div_start = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in      = ST_TOK_WAIT;
         end
         ST_TOK_WAIT: begin
            cmd.div_sel = SEL_TOKEN;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_RED_START;
            end
         end
         ST_RED_START: begin
            cmd.div_sel   = SEL_OFFSET;
            cmd.div_start = 1'b1;
            state_in      = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            cmd.div_sel = SEL_OFFSET;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_POS_START;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_RED_START;
               end
            end
         end
         ST_POS_START: begin
            cmd.div_sel   = SEL_POS;
            cmd.div_start = 1'b1;
            state_in      = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            cmd.div_sel = SEL_POS;
            if (status.div_done) begin
               cmd.div_store   = 1'b1;
               cmd.stale_clear = 1'b1;
               state_in        = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.base_load = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in      = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MXPD_ASSERT_IMPLIES(a_ready_when_quiet, clock, reset, cmd.ready, status.pipe_empty && !status.div_busy)
   `MXPD_ASSERT_IMPLIES(a_start_when_free, clock, reset, cmd.div_start, !status.div_busy)

endmodule

// ===== hdl/mxpd_datapath.sv =====
// Datapath: counters, offset registers, pad memory, read pipeline and result register.
// Depends on mxpd_pkg, mxpd_rem and the assertion macro header.
`include "multi_offset_xor_pad_decrypt_top_defines.svh"
module mxpd_datapath #(
   parameter int PAD_DEPTH   = 131072,
   parameter int NUM_OFFSETS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mxpd_pkg::cmd_type                 cmd,
   output mxpd_pkg::status_type              status,
   input  logic                              req_tvalid,
   input  logic                              in_command,
   input  logic [mxpd_pkg::BYTE_W-1:0]       in_byte,
   input  logic                              in_first,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [mxpd_pkg::BYTE_W-1:0]       rsp_tdata,
   input  logic [mxpd_pkg::PAD_LENGTH_W-1:0] pad_length,
   input  logic [mxpd_pkg::TOKEN_W-1:0]      pad_shift,
   input  logic                              cfg_write
);
   import mxpd_pkg::*;

   localparam int AW   = $clog2(PAD_DEPTH);
   localparam int SW   = AW + 1;
   localparam int LW   = $clog2(PAD_DEPTH + 1);
   localparam int CW   = (LW > PAD_LENGTH_W) ? LW : PAD_LENGTH_W;
   localparam int IW   = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;
   localparam int HB   = NUM_OFFSETS * WORD_BYTES;
   localparam int HCW  = $clog2(HB + 1);

   logic [CW-1:0]         len_ext;
   logic [LW-1:0]         len_use;
   logic [SW-1:0]         len_wide;

   logic                  take;
   logic [HCW-1:0]        hc_ff, hc_eff, hc_next;
   logic [DIVIDEND_W-1:0] asm_ff, asm_eff;
   logic                  hdr_active;
   logic [AW-1:0]         pos_ff;
   logic [AW-1:0]         wptr_ff, wr_addr;
   logic                  pad_we;
   logic                  file_take;
   logic                  stale_ff;
   logic [IW-1:0]         idx_ff;
   logic [IW-1:0]         slot;
   logic [HCW-1:0]        slot_full;
   logic [AW-1:0]         ofs_ff [NUM_OFFSETS];
   logic [AW-1:0]         red_ff [NUM_OFFSETS];
   logic [AW-1:0]         tok_ff;
   logic [AW-1:0]         base_ff;
   logic [SW-1:0]         base_sum, addr_sum;
   logic [AW-1:0]         addr_ff, addr_in;
   logic                  v1_ff, v2_ff;
   logic [BYTE_W-1:0]     pad_mem [PAD_DEPTH];
   logic [BYTE_W-1:0]     rd_ff;
   logic [BYTE_W-1:0]     byte_ff;
   logic [BYTE_W-1:0]     acc_ff;
   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     rsp_data_ff;
   logic [DIVIDEND_W-1:0] div_operand;
   logic                  div_busy, div_done;
   logic [LW-1:0]         div_rem;
   logic [AW-1:0]         div_rem_a;

   always_comb begin
      len_ext = CW'(pad_length);
      if (len_ext == '0) begin
         len_use = LW'(1);
      end else if (len_ext > CW'(PAD_DEPTH)) begin
         len_use = LW'(PAD_DEPTH);
      end else begin
         len_use = LW'(len_ext);
      end
      len_wide = SW'(len_use);
   end

   assign take       = req_tvalid & cmd.ready;
   assign hc_eff     = in_first ? '0 : hc_ff;
   assign asm_eff    = in_first ? '0 : asm_ff;
   assign hdr_active = hc_eff < HCW'(HB);
   assign hc_next    = hc_eff + HCW'(1);
   assign pad_we     = take & (in_command == CMD_PAD);
   assign file_take  = take & (in_command == CMD_FILE);
   assign wr_addr    = in_first ? '0 : wptr_ff;
   assign slot_full  = (hc_ff >> 2) - HCW'(1);
   assign slot       = IW'(slot_full);
   assign div_rem_a  = AW'(div_rem);

   always_comb begin
      case (cmd.div_sel)
         SEL_ASM:    div_operand = asm_ff;
         SEL_TOKEN:  div_operand = pad_shift;
         SEL_OFFSET: div_operand = DIVIDEND_W'(ofs_ff[idx_ff]);
         SEL_POS:    div_operand = DIVIDEND_W'(pos_ff);
         default:    div_operand = asm_ff;
      endcase
   end

   mxpd_rem #(
      .LW (LW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_operand),
      .divisor  (len_use),
      .busy     (div_busy),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_comb begin
      base_sum = SW'(pos_ff) + SW'(tok_ff);
      addr_sum = SW'(red_ff[idx_ff]) + SW'(base_ff);
      if (addr_sum >= len_wide) begin
         addr_in = AW'(addr_sum - len_wide);
      end else begin
         addr_in = AW'(addr_sum);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= '0;
         asm_ff       <= '0;
         pos_ff       <= '0;
         wptr_ff      <= '0;
         stale_ff     <= 1'b1;
         idx_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pad_we) begin
            wptr_ff <= (wr_addr == AW'(PAD_DEPTH - 1)) ? '0 : wr_addr + AW'(1);
         end
         if (file_take) begin
            if (in_first) begin
               pos_ff <= '0;
            end
            if (hdr_active) begin
               asm_ff <= {asm_eff[DIVIDEND_W-BYTE_W-1:0], in_byte};
               hc_ff  <= hc_next;
            end else begin
               asm_ff <= asm_eff;
               hc_ff  <= hc_eff;
            end
         end
         if (cmd.div_store && cmd.div_sel == SEL_POS) begin
            pos_ff <= div_rem_a;
         end
         if (cmd.finish) begin
            pos_ff <= (SW'(pos_ff) + SW'(1) == len_wide) ? '0 : pos_ff + AW'(1);
         end
         if (cfg_write) begin
            stale_ff <= 1'b1;
         end else if (cmd.stale_clear) begin
            stale_ff <= 1'b0;
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= in_byte;
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            SEL_ASM: begin
               ofs_ff[slot] <= div_rem_a;
               red_ff[slot] <= div_rem_a;
            end
            SEL_OFFSET: red_ff[idx_ff] <= div_rem_a;
            SEL_TOKEN:  tok_ff         <= div_rem_a;
            default:    ;
         endcase
      end
      if (cmd.base_load) begin
         base_ff <= (base_sum >= len_wide) ? AW'(base_sum - len_wide) : AW'(base_sum);
         acc_ff  <= byte_ff;
      end else if (v2_ff) begin
         acc_ff <= acc_ff ^ rd_ff;
      end
      if (cmd.issue) begin
         addr_ff <= addr_in;
      end
      if (cmd.finish) begin
         rsp_data_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pad_we) begin
         pad_mem[wr_addr] <= in_byte;
      end
      rd_ff <= pad_mem[addr_ff];
   end

   always_comb begin
      status.accept_hdr_word = file_take & hdr_active & (hc_next[1:0] == 2'b00);
      status.accept_data     = file_take & ~hdr_active;
      status.stale           = stale_ff;
      status.div_busy        = div_busy;
      status.div_done        = div_done;
      status.idx_last        = idx_ff == IW'(NUM_OFFSETS - 1);
      status.pipe_empty      = ~v1_ff & ~v2_ff;
      status.out_free        = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MXPD_ASSERT_IMPLIES(a_addr_in_range, clock, reset, v1_ff, SW'(addr_ff) < len_wide)
   `MXPD_ASSERT_NEXT(a_finish_loads, clock, reset, cmd.finish, rsp_valid_ff && !v1_ff && !v2_ff)

endmodule

// ===== hdl/multi_offset_xor_pad_decrypt_top.sv =====
// Pad byte: accepted while idle, no result. Header byte: every fourth starts the
// bit-serial 32-bit remainder unit and waits for it. File byte: one pad read a cycle;
// the next byte waits until the result is loaded, and a held result stalls that. First
// file byte after reset or a configuration write: NUM_OFFSETS + 2 more remainder passes
// for re-reduction. Reset is synchronous: counters clear, registers take defaults; pad
// memory and offsets stay undefined until written, with no clearing pass.
module multi_offset_xor_pad_decrypt_top #(
   parameter int PAD_DEPTH   = 131072,
   parameter int NUM_OFFSETS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // byte_value[7:0], first[8]
   input  logic                              req_tuser,   // command[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mxpd_pkg::BYTE_W-1:0]       rsp_tdata,   // plain_byte[7:0]
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mxpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mxpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mxpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import mxpd_pkg::*;

   logic [PAD_LENGTH_W-1:0] pad_length_ff;
   logic [TOKEN_W-1:0]      pad_shift_ff;
   logic                    csr_write;
   logic                    reg_index;
   cmd_type                 cmd;
   status_type              status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_length_ff <= PAD_LENGTH_RESET;
         pad_shift_ff  <= TOKEN_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_PAD_LENGTH: pad_length_ff <= csr_pwdata[PAD_LENGTH_W-1:0];
            REG_PAD_SHIFT:  pad_shift_ff  <= csr_pwdata[TOKEN_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PAD_LENGTH: csr_prdata = CSR_DATA_W'(pad_length_ff);
         REG_PAD_SHIFT:  csr_prdata = CSR_DATA_W'(pad_shift_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req_tready = cmd.ready;

   mxpd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mxpd_datapath #(
      .PAD_DEPTH   (PAD_DEPTH),
      .NUM_OFFSETS (NUM_OFFSETS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .in_command (req_tuser),
      .in_byte    (req_tdata[BYTE_W-1:0]),
      .in_first   (req_tdata[BYTE_W]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .pad_length (pad_length_ff),
      .pad_shift  (pad_shift_ff),
      .cfg_write  (csr_write)
   );

endmodule
